/* rtl/bpfm_pkg.sv */
`default_nettype none
package bpfm_pkg;

   localparam int FRAMES     = 16;
   localparam int FRAME_BITS = 4;
   localparam int DEPTH_BITS = 5;
   localparam int PIN_BITS   = 8;
   localparam int PAGE_BITS  = 32;

   localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

   localparam logic [2:0] FN_FETCH     = 3'd0;
   localparam logic [2:0] FN_UNPIN     = 3'd1;
   localparam logic [2:0] FN_NEW       = 3'd2;
   localparam logic [2:0] FN_DELETE    = 3'd3;
   localparam logic [2:0] FN_FLUSH     = 3'd4;
   localparam logic [2:0] FN_FLUSH_ALL = 3'd5;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_RES   = 3'd1;
   localparam logic [2:0] ST_NO_FRAME  = 3'd2;
   localparam logic [2:0] ST_UNPINNED  = 3'd3;
   localparam logic [2:0] ST_PINNED    = 3'd4;

   // frame cell operations
   localparam logic [2:0] FC_NONE  = 3'd0;
   localparam logic [2:0] FC_LOAD  = 3'd1;
   localparam logic [2:0] FC_INC   = 3'd2;
   localparam logic [2:0] FC_DEC   = 3'd3;
   localparam logic [2:0] FC_FREE  = 3'd4;
   localparam logic [2:0] FC_CLEAN = 3'd5;

   // lru cell operations
   localparam logic [1:0] LR_NONE   = 2'd0;
   localparam logic [1:0] LR_REMOVE = 2'd1;
   localparam logic [1:0] LR_APPEND = 2'd2;

   typedef struct packed {
      logic [2:0]           func;
      logic [PAGE_BITS-1:0] page_number;
      logic                 mark_dirty;
      logic [PAGE_BITS-1:0] allocated_page;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [FRAME_BITS-1:0] frame_index;
      logic                  read_request;
      logic                  write_request;
      logic [PAGE_BITS-1:0]  write_page;
      logic                  dealloc_request;
      logic [DEPTH_BITS-1:0] free_frames;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]           op;
      logic [PAGE_BITS-1:0] page;
      logic                 dirty;
   } frame_cmd_type;

   typedef struct packed {
      logic                 valid;
      logic                 dirty;
      logic [PIN_BITS-1:0]  pin;
      logic [PAGE_BITS-1:0] page;
   } frame_stat_type;

   typedef struct packed {
      logic [1:0]            op;
      logic [FRAME_BITS-1:0] frame;
      logic [DEPTH_BITS-1:0] depth;
   } lru_cmd_type;

endpackage
`default_nettype wire

/* rtl/bpfm_frame_cell.sv */
`default_nettype none
module bpfm_frame_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bpfm_pkg::frame_cmd_type  cmd,
   input  wire logic [bpfm_pkg::PAGE_BITS-1:0] look_page,
   input  wire logic                     hit_in,
   output logic                          hit_out,
   output logic                          first,
   output bpfm_pkg::frame_stat_type      stat
);
   logic                               valid_ff, valid_in;
   logic                               dirty_ff, dirty_in;
   logic [bpfm_pkg::PIN_BITS-1:0]      pin_ff, pin_in;
   logic [bpfm_pkg::PAGE_BITS-1:0]     page_ff, page_in;
   logic                               hit;

   assign hit     = valid_ff && (page_ff == look_page);
   assign first   = hit && !hit_in;
   assign hit_out = hit || hit_in;
   assign stat    = '{valid: valid_ff, dirty: dirty_ff, pin: pin_ff, page: page_ff};

   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      pin_in   = pin_ff;
      page_in  = page_ff;
      unique case (cmd.op)
         bpfm_pkg::FC_LOAD: begin
            valid_in = 1'b1;
            dirty_in = cmd.dirty;
            pin_in   = bpfm_pkg::PIN_BITS'(1);
            page_in  = cmd.page;
         end
         bpfm_pkg::FC_INC: begin
            if (pin_ff != bpfm_pkg::PIN_MAX) pin_in = pin_ff + 1'b1;
         end
         bpfm_pkg::FC_DEC: begin
            pin_in = pin_ff - 1'b1;
            if (cmd.dirty) dirty_in = 1'b1;
         end
         bpfm_pkg::FC_FREE: begin
            valid_in = 1'b0;
            dirty_in = 1'b0;
            pin_in   = '0;
         end
         bpfm_pkg::FC_CLEAN: dirty_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      if (reset) begin
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
         pin_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         pin_ff   <= pin_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/bpfm_lru_cell.sv */
`default_nettype none
module bpfm_lru_cell (
   input  wire logic                              clock,
   input  wire logic [bpfm_pkg::FRAME_BITS-1:0]   position,
   input  wire bpfm_pkg::lru_cmd_type             cmd,
   input  wire logic                              present,
   input  wire logic [bpfm_pkg::FRAME_BITS-1:0]   next_val,
   input  wire logic                              seen_in,
   output logic                                   seen_out,
   output logic [bpfm_pkg::FRAME_BITS-1:0]        val
);
   logic [bpfm_pkg::FRAME_BITS-1:0] val_ff, val_in;
   logic [bpfm_pkg::DEPTH_BITS-1:0] pos_w;
   logic                            occupied;

   assign pos_w    = {1'b0, position};
   assign occupied = pos_w < cmd.depth;
   assign seen_out = seen_in || (occupied && (val_ff == cmd.frame));
   assign val      = val_ff;

   always_comb begin
      val_in = val_ff;
      unique case (cmd.op)
         // entries from the match onward move one toward the oldest end
         bpfm_pkg::LR_REMOVE: if (seen_out && (pos_w + 1'b1 < cmd.depth)) val_in = next_val;
         bpfm_pkg::LR_APPEND: if (pos_w == cmd.depth && !present) val_in = cmd.frame;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end
endmodule
`default_nettype wire

/* rtl/buffer_pool_frame_manager_unit.sv */
`default_nettype none
// buffer pool frame manager
// req channel: one word per request (fetch, unpin, new, delete, flush, flush all),
// taken when req_valid is high and req_stall is low. req_stall stays high
// while a request is in work, so requests are handled one at a time.
// rsp channel: one word per result, held in an output register until taken
// (rsp_valid high, rsp_stall low). last marks the final word of a request.
// a request passes from acceptance to its result word through a lookup over the
// frame cells, a state update and the result, which waits while the receiver
// stalls; the next request is taken in the cycle after the result is loaded.
// flush all scans the frame cells one per cycle up to the last dirty frame,
// holding on a dirty frame while the receiver stalls, and emits one word per
// dirty frame, or a single word when no frame is dirty.
// the lru order lives in a row of cells that shift toward the oldest end on
// removal; the free stack is filled with frames popped 0 first.
// reset (synchronous, active high) empties all frames, fills the free stack
// and empties the lru order; no clearing pass is needed.
module buffer_pool_frame_manager_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire bpfm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output bpfm_pkg::rsp_type      rsp_data
);
   localparam int FR = bpfm_pkg::FRAMES;
   localparam int FB = bpfm_pkg::FRAME_BITS;
   localparam int DB = bpfm_pkg::DEPTH_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOOK  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0]             state_ff, state_in;
   bpfm_pkg::req_type      req_ff;
   logic                   hit_ff;
   logic [FB-1:0]          hit_idx_ff, hit_idx;
   logic [FB-1:0]          scan_ff, scan_in;
   bpfm_pkg::rsp_type      pend_ff, pend_in;
   logic                   rsp_valid_ff;
   bpfm_pkg::rsp_type      rsp_ff, rsp_in;
   logic                   rsp_load;
   logic [FB-1:0]          stack_ff [FR];
   logic [DB-1:0]          free_depth_ff, lru_depth_ff;

   bpfm_pkg::frame_cmd_type  fcmd [FR];
   bpfm_pkg::frame_stat_type fstat [FR];
   logic [FR:0]              fhit_chain;
   logic [FR-1:0]            ffirst;
   logic [FR-1:0]            dirty_mask;
   logic [FR-1:0]            later;
   logic [bpfm_pkg::PAGE_BITS-1:0] look_page;

   bpfm_pkg::lru_cmd_type    lcmd;
   logic [FR:0]              lseen;
   logic [FB-1:0]            lval [FR];
   logic [FB-1:0]            lnext [FR];
   logic                     present;

   logic                     out_free;
   logic                     pop, push;
   logic [FB-1:0]            push_frame;
   logic [DB-1:0]            fd_m1;
   logic [2:0]               sel_op;
   logic [FB-1:0]            sel_frame;
   logic                     sel_dirty;
   logic [bpfm_pkg::PAGE_BITS-1:0] sel_page;
   logic                     take_ok;
   logic [FB-1:0]            take_f;
   logic                     take_wr;
   logic [bpfm_pkg::PAGE_BITS-1:0] take_wpage;
   bpfm_pkg::frame_stat_type hs, vs;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign look_page = req_ff.page_number;
   assign fd_m1     = free_depth_ff - 1'b1;

   assign fhit_chain[0] = 1'b0;
   assign lseen[0]      = 1'b0;
   assign present       = lseen[FR];

   for (genvar k = 0; k < FR; k++) begin : g_cells
      bpfm_frame_cell u_frame (
         .clock     (clock),
         .reset     (reset),
         .cmd       (fcmd[k]),
         .look_page (look_page),
         .hit_in    (fhit_chain[k]),
         .hit_out   (fhit_chain[k+1]),
         .first     (ffirst[k]),
         .stat      (fstat[k])
      );
      assign dirty_mask[k] = fstat[k].valid && fstat[k].dirty;
      assign later[k]      = dirty_mask[k] && (FB'(k) > scan_ff);
      if (k + 1 < FR) begin : g_nx
         assign lnext[k] = lval[k+1];
      end else begin : g_last
         assign lnext[k] = lval[k];
      end
      bpfm_lru_cell u_lru (
         .clock    (clock),
         .position (FB'(k)),
         .cmd      (lcmd),
         .present  (present),
         .next_val (lnext[k]),
         .seen_in  (lseen[k]),
         .seen_out (lseen[k+1]),
         .val      (lval[k])
      );
   end

   always_comb begin
      hit_idx = '0;
      for (int k = 0; k < FR; k++) begin
         if (ffirst[k]) hit_idx = FB'(k);
      end
   end

   assign hs = fstat[hit_idx_ff];
   assign vs = fstat[lval[0]];

   // frame for a miss or a new page: free stack first, else the oldest unpinned
   always_comb begin
      take_ok    = 1'b0;
      take_f     = '0;
      take_wr    = 1'b0;
      take_wpage = '0;
      if (free_depth_ff != '0) begin
         take_ok = 1'b1;
         take_f  = stack_ff[fd_m1[FB-1:0]];
      end else if (lru_depth_ff != '0) begin
         take_ok = 1'b1;
         take_f  = lval[0];
         take_wr = vs.valid && vs.dirty;
         if (take_wr) take_wpage = vs.page;
      end
   end

   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      pend_in    = pend_ff;
      rsp_in     = rsp_ff;
      rsp_load   = 1'b0;
      pop        = 1'b0;
      push       = 1'b0;
      push_frame = hit_idx_ff;
      sel_op     = bpfm_pkg::FC_NONE;
      sel_frame  = hit_idx_ff;
      sel_dirty  = 1'b0;
      sel_page   = req_ff.page_number;
      lcmd       = '{op: bpfm_pkg::LR_NONE, frame: hit_idx_ff, depth: lru_depth_ff};

      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_LOOK;
         S_LOOK: state_in = S_EXEC;
         S_EXEC: begin
            pend_in  = '0;
            pend_in.last = 1'b1;
            state_in = S_EMIT;
            unique case (req_ff.func)
               bpfm_pkg::FN_FETCH, bpfm_pkg::FN_NEW: begin
                  if (req_ff.func == bpfm_pkg::FN_FETCH && hit_ff) begin
                     sel_op  = bpfm_pkg::FC_INC;
                     lcmd.op = bpfm_pkg::LR_REMOVE;
                     pend_in.frame_index = hit_idx_ff;
                  end else if (!take_ok) begin
                     pend_in.status = bpfm_pkg::ST_NO_FRAME;
                  end else begin
                     if (free_depth_ff != '0) begin
                        pop = 1'b1;
                     end else begin
                        lcmd.op    = bpfm_pkg::LR_REMOVE;
                        lcmd.frame = take_f;
                     end
                     sel_op    = bpfm_pkg::FC_LOAD;
                     sel_frame = take_f;
                     if (req_ff.func == bpfm_pkg::FN_NEW) begin
                        sel_dirty = 1'b1;
                        sel_page  = req_ff.allocated_page;
                     end else begin
                        pend_in.read_request = 1'b1;
                     end
                     pend_in.frame_index   = take_f;
                     pend_in.write_request = take_wr;
                     pend_in.write_page    = take_wpage;
                  end
               end
               bpfm_pkg::FN_UNPIN: begin
                  if (!hit_ff) begin
                     pend_in.status = bpfm_pkg::ST_NOT_RES;
                  end else if (hs.pin == '0) begin
                     pend_in.status      = bpfm_pkg::ST_UNPINNED;
                     pend_in.frame_index = hit_idx_ff;
                  end else begin
                     sel_op    = bpfm_pkg::FC_DEC;
                     sel_dirty = req_ff.mark_dirty;
                     if (hs.pin == bpfm_pkg::PIN_BITS'(1)) lcmd.op = bpfm_pkg::LR_APPEND;
                     pend_in.frame_index = hit_idx_ff;
                  end
               end
               bpfm_pkg::FN_DELETE: begin
                  if (!hit_ff) begin
                     pend_in.dealloc_request = 1'b1;
                  end else if (hs.pin != '0) begin
                     pend_in.status      = bpfm_pkg::ST_PINNED;
                     pend_in.frame_index = hit_idx_ff;
                  end else begin
                     sel_op  = bpfm_pkg::FC_FREE;
                     lcmd.op = bpfm_pkg::LR_REMOVE;
                     push    = 1'b1;
                     pend_in.frame_index     = hit_idx_ff;
                     pend_in.dealloc_request = 1'b1;
                  end
               end
               bpfm_pkg::FN_FLUSH: begin
                  if (!hit_ff) begin
                     pend_in.status = bpfm_pkg::ST_NOT_RES;
                  end else begin
                     sel_op = bpfm_pkg::FC_CLEAN;
                     pend_in.frame_index   = hit_idx_ff;
                     pend_in.write_request = hs.dirty;
                     if (hs.dirty) pend_in.write_page = req_ff.page_number;
                  end
               end
               bpfm_pkg::FN_FLUSH_ALL: begin
                  scan_in = '0;
                  if (dirty_mask != '0) state_in = S_FLUSH;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_in   = pend_ff;
               rsp_in.free_frames = free_depth_ff + lru_depth_ff;
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (!dirty_mask[scan_ff]) begin
               scan_in = scan_ff + 1'b1;
            end else if (out_free) begin
               sel_op    = bpfm_pkg::FC_CLEAN;
               sel_frame = scan_ff;
               rsp_load  = 1'b1;
               rsp_in    = '0;
               rsp_in.frame_index   = scan_ff;
               rsp_in.write_request = 1'b1;
               rsp_in.write_page    = fstat[scan_ff].page;
               rsp_in.free_frames   = free_depth_ff + lru_depth_ff;
               rsp_in.last          = (later == '0);
               if (later == '0) state_in = S_IDLE;
               else scan_in = scan_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      for (int k = 0; k < FR; k++) begin
         fcmd[k] = '{op: bpfm_pkg::FC_NONE, page: sel_page, dirty: sel_dirty};
         if (FB'(k) == sel_frame) fcmd[k].op = sel_op;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) req_ff <= req_data;
      if (state_ff == S_LOOK) begin
         hit_ff     <= fhit_chain[FR];
         hit_idx_ff <= hit_idx;
      end
      scan_ff <= scan_in;
      pend_ff <= pend_in;
      if (rsp_load) rsp_ff <= rsp_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         free_depth_ff <= DB'(FR);
         lru_depth_ff  <= '0;
         for (int k = 0; k < FR; k++) stack_ff[k] <= FB'(FR - 1 - k);
      end else begin
         state_ff <= state_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (pop) begin
            free_depth_ff <= fd_m1;
         end else if (push && free_depth_ff < DB'(FR)) begin
            free_depth_ff <= free_depth_ff + 1'b1;
            stack_ff[free_depth_ff[FB-1:0]] <= push_frame;
         end
         if (lcmd.op == bpfm_pkg::LR_REMOVE && present) begin
            lru_depth_ff <= lru_depth_ff - 1'b1;
         end else if (lcmd.op == bpfm_pkg::LR_APPEND && !present && lru_depth_ff < DB'(FR)) begin
            lru_depth_ff <= lru_depth_ff + 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

/* tb/sv/tb_buffer_pool_frame_manager_unit.sv */
`default_nettype none

class frame_pool_board;
   bpfm_pkg::rsp_type    pending_q[$];
   int                   errors;
   int                   mismatches;
   int                   checked;
   logic [bpfm_pkg::PAGE_BITS-1:0] page_of[bpfm_pkg::FRAMES];
   bit                   held[bpfm_pkg::FRAMES];
   logic [bpfm_pkg::PIN_BITS-1:0]  pins[bpfm_pkg::FRAMES];
   bit                   dirty[bpfm_pkg::FRAMES];
   int                   free_stk[bpfm_pkg::FRAMES];
   int                   free_cnt;
   int                   lru_q[$];

   function new();
      for (int i = 0; i < bpfm_pkg::FRAMES; i++) begin
         held[i] = 1'b0;
         pins[i] = '0;
         dirty[i] = 1'b0;
         page_of[i] = '0;
         free_stk[i] = bpfm_pkg::FRAMES - 1 - i;
      end
      free_cnt = bpfm_pkg::FRAMES;
      errors = 0;
      mismatches = 0;
      checked = 0;
   endfunction

   function int lookup(logic [bpfm_pkg::PAGE_BITS-1:0] pg);
      for (int i = 0; i < bpfm_pkg::FRAMES; i++)
         if (held[i] && page_of[i] == pg) return i;
      return -1;
   endfunction

   function void lru_drop(int f);
      for (int i = 0; i < lru_q.size(); i++)
         if (lru_q[i] == f) begin
            lru_q.delete(i);
            return;
         end
   endfunction

   function void lru_push(int f);
      foreach (lru_q[i]) if (lru_q[i] == f) return;
      if (lru_q.size() < bpfm_pkg::FRAMES) lru_q.insert(lru_q.size(), f);
   endfunction

   // free stack first, else the oldest unpinned frame
   function int grab(output bit wr, output logic [bpfm_pkg::PAGE_BITS-1:0] wpage);
      int f;
      wr = 1'b0;
      wpage = '0;
      if (free_cnt > 0) begin
         free_cnt--;
         return free_stk[free_cnt];
      end
      if (lru_q.size() == 0) return -1;
      f = lru_q[0];
      lru_drop(f);
      if (held[f] && dirty[f]) begin
         wr = 1'b1;
         wpage = page_of[f];
      end
      held[f] = 1'b0;
      dirty[f] = 1'b0;
      pins[f] = '0;
      return f;
   endfunction

   function void add(logic [2:0] st, int f, bit rd, bit wr,
                     logic [bpfm_pkg::PAGE_BITS-1:0] wp, bit dea, bit lst);
      bpfm_pkg::rsp_type r;
      r.status = st;
      r.frame_index = f[bpfm_pkg::FRAME_BITS-1:0];
      r.read_request = rd;
      r.write_request = wr;
      r.write_page = wp;
      r.dealloc_request = dea;
      r.free_frames = bpfm_pkg::DEPTH_BITS'(free_cnt + lru_q.size());
      r.last = lst;
      pending_q.insert(pending_q.size(), r);
   endfunction

   function void note(bpfm_pkg::req_type w);
      int f;
      int n;
      bit wr;
      logic [bpfm_pkg::PAGE_BITS-1:0] wp;
      case (w.func)
         bpfm_pkg::FN_FETCH: begin
            f = lookup(w.page_number);
            if (f >= 0) begin
               if (pins[f] != bpfm_pkg::PIN_MAX) pins[f]++;
               lru_drop(f);
               add(bpfm_pkg::ST_OK, f, 1'b0, 1'b0, '0, 1'b0, 1'b1);
            end else begin
               f = grab(wr, wp);
               if (f < 0) add(bpfm_pkg::ST_NO_FRAME, 0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
               else begin
                  page_of[f] = w.page_number;
                  held[f] = 1'b1;
                  pins[f] = bpfm_pkg::PIN_BITS'(1);
                  dirty[f] = 1'b0;
                  add(bpfm_pkg::ST_OK, f, 1'b1, wr, wp, 1'b0, 1'b1);
               end
            end
         end
         bpfm_pkg::FN_UNPIN: begin
            f = lookup(w.page_number);
            if (f < 0) add(bpfm_pkg::ST_NOT_RES, 0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
            else if (pins[f] == '0) add(bpfm_pkg::ST_UNPINNED, f, 1'b0, 1'b0, '0, 1'b0, 1'b1);
            else begin
               pins[f]--;
               if (w.mark_dirty) dirty[f] = 1'b1;
               if (pins[f] == '0) lru_push(f);
               add(bpfm_pkg::ST_OK, f, 1'b0, 1'b0, '0, 1'b0, 1'b1);
            end
         end
         bpfm_pkg::FN_NEW: begin
            f = grab(wr, wp);
            if (f < 0) add(bpfm_pkg::ST_NO_FRAME, 0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
            else begin
               page_of[f] = w.allocated_page;
               held[f] = 1'b1;
               pins[f] = bpfm_pkg::PIN_BITS'(1);
               dirty[f] = 1'b1;
               add(bpfm_pkg::ST_OK, f, 1'b0, wr, wp, 1'b0, 1'b1);
            end
         end
         bpfm_pkg::FN_DELETE: begin
            f = lookup(w.page_number);
            if (f < 0) add(bpfm_pkg::ST_OK, 0, 1'b0, 1'b0, '0, 1'b1, 1'b1);
            else if (pins[f] != '0) add(bpfm_pkg::ST_PINNED, f, 1'b0, 1'b0, '0, 1'b0, 1'b1);
            else begin
               lru_drop(f);
               held[f] = 1'b0;
               dirty[f] = 1'b0;
               pins[f] = '0;
               if (free_cnt < bpfm_pkg::FRAMES) begin
                  free_stk[free_cnt] = f;
                  free_cnt++;
               end
               add(bpfm_pkg::ST_OK, f, 1'b0, 1'b0, '0, 1'b1, 1'b1);
            end
         end
         bpfm_pkg::FN_FLUSH: begin
            f = lookup(w.page_number);
            if (f < 0) add(bpfm_pkg::ST_NOT_RES, 0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
            else begin
               wr = dirty[f];
               dirty[f] = 1'b0;
               add(bpfm_pkg::ST_OK, f, 1'b0, wr, wr ? w.page_number : '0, 1'b0, 1'b1);
            end
         end
         bpfm_pkg::FN_FLUSH_ALL: begin
            n = 0;
            for (int i = 0; i < bpfm_pkg::FRAMES; i++)
               if (held[i] && dirty[i]) begin
                  dirty[i] = 1'b0;
                  add(bpfm_pkg::ST_OK, i, 1'b0, 1'b1, page_of[i], 1'b0, 1'b0);
                  n++;
               end
            if (n == 0) add(bpfm_pkg::ST_OK, 0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
            else pending_q[pending_q.size()-1].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   function void check(bpfm_pkg::rsp_type got);
      bpfm_pkg::rsp_type want;
      checked++;
      if (pending_q.size() == 0) begin
         errors++;
         if (mismatches < 10) $display("unexpected result word %h", got);
         mismatches++;
         return;
      end
      want = pending_q[0];
      pending_q.delete(0);
      if (got.status !== want.status || got.frame_index !== want.frame_index ||
          got.read_request !== want.read_request ||
          got.write_request !== want.write_request ||
          got.write_page !== want.write_page ||
          got.dealloc_request !== want.dealloc_request ||
          got.free_frames !== want.free_frames || got.last !== want.last) begin
         errors++;
         if (mismatches < 10) begin
            $display("mismatch: exp st=%0d fr=%0d rd=%b wr=%b wp=%h dea=%b free=%0d last=%b",
                     want.status, want.frame_index, want.read_request, want.write_request,
                     want.write_page, want.dealloc_request, want.free_frames, want.last);
            $display("          got st=%0d fr=%0d rd=%b wr=%b wp=%h dea=%b free=%0d last=%b",
                     got.status, got.frame_index, got.read_request, got.write_request,
                     got.write_page, got.dealloc_request, got.free_frames, got.last);
         end
         mismatches++;
      end
   endfunction
endclass

module tb_buffer_pool_frame_manager_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] FN_RSV6 = 3'd6;
   localparam logic [2:0] FN_RSV7 = 3'd7;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   bpfm_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   bpfm_pkg::rsp_type rsp_data;

   frame_pool_board board;
   int src_pct;
   int dst_pct;
   int hold_cycles;
   int sent;

   buffer_pool_frame_manager_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("tb_buffer_pool_frame_manager_unit: errors");
      $finish;
   end

   // receiver: random stall, or a long counted hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else
            rsp_stall <= ($urandom_range(99) < dst_pct);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) board.check(rsp_data);

   task automatic send_word(bpfm_pkg::req_type w);
      while ($urandom_range(99) < src_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      board.note(w);
      sent++;
   endtask

   task automatic send_op(logic [2:0] fn, logic [31:0] pg, bit md, logic [31:0] ap);
      bpfm_pkg::req_type w;
      w.func = fn;
      w.page_number = pg;
      w.mark_dirty = md;
      w.allocated_page = ap;
      send_word(w);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_page();
      int k;
      k = $urandom_range(99);
      if (k < 4) return 32'hFFFF_FFFF;
      if (k < 8) return 32'h0;
      if (k < 14) return $urandom;
      return 32'h1000 + $urandom_range(23);
   endfunction

   task automatic random_phase(int count);
      int k;
      logic [2:0] fn;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         if (k < 30) fn = bpfm_pkg::FN_FETCH;
         else if (k < 60) fn = bpfm_pkg::FN_UNPIN;
         else if (k < 70) fn = bpfm_pkg::FN_NEW;
         else if (k < 82) fn = bpfm_pkg::FN_DELETE;
         else if (k < 90) fn = bpfm_pkg::FN_FLUSH;
         else if (k < 96) fn = bpfm_pkg::FN_FLUSH_ALL;
         else fn = k[0] ? FN_RSV7 : FN_RSV6;
         send_op(fn, pick_page(), 1'($urandom_range(1)), pick_page());
      end
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      src_pct = 0;
      dst_pct = 0;
      hold_cycles = 0;
      sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners
      send_op(bpfm_pkg::FN_FETCH, 32'h0, 1'b0, 32'h0);
      send_op(bpfm_pkg::FN_FETCH, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_op(bpfm_pkg::FN_FETCH, 32'h0, 1'b0, 32'h0);
      send_op(bpfm_pkg::FN_NEW, 32'h0, 1'b0, 32'hFFFF_FFFF);
      send_op(bpfm_pkg::FN_UNPIN, 32'hFFFF_FFFF, 1'b1, 32'h0);
      send_op(bpfm_pkg::FN_UNPIN, 32'hFFFF_FFFF, 1'b0, 32'h0);
      send_op(bpfm_pkg::FN_UNPIN, 32'h1234_5678, 1'b1, 32'h0);
      send_op(bpfm_pkg::FN_FLUSH, 32'hFFFF_FFFF, 1'b0, 32'h0);
      send_op(bpfm_pkg::FN_FLUSH, 32'hFFFF_FFFF, 1'b0, 32'h0);
      send_op(bpfm_pkg::FN_FLUSH, 32'hDEAD_BEEF, 1'b0, 32'h0);
      send_op(bpfm_pkg::FN_DELETE, 32'h0, 1'b0, 32'h0);
      send_op(bpfm_pkg::FN_DELETE, 32'hCAFE_0000, 1'b0, 32'h0);
      send_op(bpfm_pkg::FN_UNPIN, 32'h0, 1'b1, 32'h0);
      send_op(bpfm_pkg::FN_UNPIN, 32'h0, 1'b0, 32'h0);
      send_op(bpfm_pkg::FN_DELETE, 32'h0, 1'b0, 32'h0);
      send_op(bpfm_pkg::FN_FLUSH_ALL, 32'h0, 1'b0, 32'h0);
      send_op(bpfm_pkg::FN_FLUSH_ALL, 32'h0, 1'b0, 32'h0);
      send_op(bpfm_pkg::FN_NEW, 32'h0, 1'b0, 32'hFFFF_FFFF);
      send_op(bpfm_pkg::FN_NEW, 32'h0, 1'b0, 32'h8000_0001);
      send_op(bpfm_pkg::FN_FETCH, 32'h8000_0001, 1'b0, 32'h0);
      send_op(FN_RSV6, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_op(FN_RSV7, 32'h0, 1'b0, 32'h0);
      send_op(bpfm_pkg::FN_FLUSH_ALL, 32'h0, 1'b0, 32'h0);
      wait_drained();

      // repeated pins, then release with a dirty mark
      for (int i = 0; i < 5; i++) send_op(bpfm_pkg::FN_FETCH, 32'h5A5A_5A5A, 1'b0, 32'h0);
      for (int i = 0; i < 5; i++) send_op(bpfm_pkg::FN_UNPIN, 32'h5A5A_5A5A, (i == 3), 32'h0);
      send_op(bpfm_pkg::FN_DELETE, 32'h5A5A_5A5A, 1'b0, 32'h0);

      random_phase(40);
      src_pct = 72;
      random_phase(40);
      src_pct = 0;
      dst_pct = 72;
      random_phase(40);
      src_pct = 11;
      dst_pct = 11;
      random_phase(25);

      // long receiver hold-off while the sender keeps offering words
      src_pct = 0;
      dst_pct = 0;
      hold_cycles = 300;
      random_phase(20);
      wait_drained();

      // fill the pool with dirty new pages to force dirty evictions and no-frame
      for (int i = 0; i < 18; i++) send_op(bpfm_pkg::FN_NEW, 32'h0, 1'b0, 32'h2000 + i);
      for (int i = 0; i < 16; i++) send_op(bpfm_pkg::FN_UNPIN, 32'h2000 + i, 1'b1, 32'h0);
      for (int i = 0; i < 4; i++) send_op(bpfm_pkg::FN_FETCH, 32'h3000 + i, 1'b0, 32'h0);
      send_op(bpfm_pkg::FN_FLUSH_ALL, 32'h0, 1'b0, 32'h0);

      wait_drained();
      $display("run: %0d request words sent, %0d result words checked, %0d mismatches",
               sent, board.checked, board.errors + board.pending_q.size());
      $display("covered all request kinds, repeated pins, eviction, stall and idle mixes");
      if (board.errors == 0 && board.pending_q.size() == 0)
         $display("tb_buffer_pool_frame_manager_unit: clean");
      else
         $display("tb_buffer_pool_frame_manager_unit: errors");
      $finish;
   end
endmodule
`default_nettype wire

/* buffer_pool_frame_manager_unit.f */
rtl/bpfm_pkg.sv
rtl/bpfm_frame_cell.sv
rtl/bpfm_lru_cell.sv
rtl/buffer_pool_frame_manager_unit.sv
tb/sv/tb_buffer_pool_frame_manager_unit.sv
